// File: design/slcm_pkg.sv
package slcm_pkg;

  // Field widths
  localparam int LEVEL_W    = 10;
  localparam int FREQ_W     = 16;
  localparam int COLOR_W    = 24;
  localparam int CH_W       = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int PROD_W     = FREQ_W + CH_W;

  // Default history length
  localparam int HIST_DEPTH_DEF = 16;

  typedef logic [LEVEL_W-1:0]    level_t;
  typedef logic [FREQ_W-1:0]     freq_t;
  typedef logic [COLOR_W-1:0]    color_t;
  typedef logic [CH_W-1:0]       chan_t;
  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;

  // Register indexes
  localparam cfg_idx_t REG_MIN_FREQ  = 3'd0;
  localparam cfg_idx_t REG_MID_FREQ  = 3'd1;
  localparam cfg_idx_t REG_MAX_FREQ  = 3'd2;
  localparam cfg_idx_t REG_LOW_COLOR = 3'd3;
  localparam cfg_idx_t REG_MID_COLOR = 3'd4;
  localparam cfg_idx_t REG_HI_COLOR  = 3'd5;
  localparam cfg_idx_t REG_LVL_FLOOR = 3'd6;

  // Reset values
  localparam freq_t  RST_MIN_FREQ  = 16'd60;
  localparam freq_t  RST_MID_FREQ  = 16'd500;
  localparam freq_t  RST_MAX_FREQ  = 16'd2000;
  localparam color_t RST_LOW_COLOR = 24'hFF0000;
  localparam color_t RST_MID_COLOR = 24'h00FF00;
  localparam color_t RST_HI_COLOR  = 24'h0000FF;
  localparam level_t RST_LVL_FLOOR = 10'd50;

  // Full-scale channel value
  localparam chan_t CH_MAX = 8'd255;

  // Channel select codes
  localparam logic [1:0] CH_RED   = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_BLUE  = 2'd2;

  // Pick one 8-bit channel out of a packed RGB word
  function automatic chan_t chan_of(color_t rgb, logic [1:0] ch);
    chan_t res;
    case (ch)
      CH_RED:   res = rgb[23:16];
      CH_GREEN: res = rgb[15:8];
      default:  res = rgb[7:0];
    endcase
    return res;
  endfunction

endpackage

// File: design/slcm_ram.sv
module slcm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AddrW-1:0] wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AddrW-1:0] rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: design/sound_level_color_mapper_top.sv
// Takes one item at a time; the next is taken the cycle after the result is loaded.
// A lit item makes seven passes through the shared multiplier and 8-step divider: each
// pass loads the product (ST_MUL), runs the divide steps (ST_DIV) and stores the quotient
// (ST_POST). The history scan reads one entry per cycle from the level RAM.
// Reset (synchronous, rst_n low) restores register defaults and empties the history.
module sound_level_color_mapper_top #(
  parameter int HISTORY_DEPTH = slcm_pkg::HIST_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  // input channel
  input  logic                in_valid,
  output logic                in_stall,
  input  slcm_pkg::level_t    in_rms_level,
  input  slcm_pkg::freq_t     in_peak_frequency,
  // result channel
  output logic                out_valid,
  input  logic                out_stall,
  output slcm_pkg::chan_t     out_red,
  output slcm_pkg::chan_t     out_green,
  output slcm_pkg::chan_t     out_blue,
  output logic                out_lit,
  // configuration
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  slcm_pkg::cfg_idx_t  cfg_index,
  input  slcm_pkg::cfg_data_t cfg_wdata
);

  import slcm_pkg::*;

  localparam int PTR_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);

  // Sequencer states
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SCAN = 3'd1;
  localparam logic [2:0] ST_GATE = 3'd2;
  localparam logic [2:0] ST_MUL  = 3'd3;
  localparam logic [2:0] ST_DIV  = 3'd4;
  localparam logic [2:0] ST_POST = 3'd5;
  localparam logic [2:0] ST_FIN  = 3'd6;

  // Shared-unit operations, in issue order
  localparam logic [2:0] OP_BRIGHT  = 3'd0;
  localparam logic [2:0] OP_BLEND_R = 3'd1;
  localparam logic [2:0] OP_BLEND_G = 3'd2;
  localparam logic [2:0] OP_BLEND_B = 3'd3;
  localparam logic [2:0] OP_SCALE_R = 3'd4;
  localparam logic [2:0] OP_SCALE_G = 3'd5;
  localparam logic [2:0] OP_SCALE_B = 3'd6;

  localparam logic [2:0] DIV_LAST = 3'd7;

  // Configuration registers
  freq_t  cfg_min_r, cfg_mid_r, cfg_max_r;
  color_t cfg_low_r, cfg_mcol_r, cfg_hcol_r;
  level_t cfg_floor_r;

  // Sequencer and datapath registers
  logic [2:0]       state_r;
  logic [2:0]       op_r;
  logic [2:0]       it_r;
  level_t           lv_r, lo_r, hi_r, newest_r;
  freq_t            fq_r;
  logic             got_new_r;
  logic [CNT_W-1:0] iss_cnt_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic             rd_pend_r;
  logic [15:0]      rem_r;
  chan_t            quo_r;
  freq_t            dvs_r;
  chan_t            bright_r;
  chan_t            base_r [3];
  chan_t            rgb_r  [3];
  logic             lit_r;

  // History bookkeeping
  logic [CNT_W-1:0] hist_cnt_r;
  logic [PTR_W-1:0] new_ptr_r;

  // Output register
  logic  out_valid_r;
  chan_t out_red_r, out_green_r, out_blue_r;
  logic  out_lit_r;

  // Combinational signals
  logic             in_acc;
  logic             fin_go;
  logic             rd_en;
  level_t           rd_data;
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr_prev;
  logic [1:0]       ch_idx;
  logic             upper;
  chan_t            a_ch, b_ch, dmag;
  logic             diff_neg;
  freq_t            seg_pos, seg_span;
  freq_t            mul_a;
  chan_t            mul_b;
  freq_t            dvs;
  logic [PROD_W-1:0] mul_prod;
  logic [16:0]      trial;
  logic             ge;
  logic             lit_now;

  assign in_acc    = in_valid && !in_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign fin_go    = (state_r == ST_FIN) && (!out_valid_r || !out_stall);

  assign out_valid = out_valid_r;
  assign out_red   = out_red_r;
  assign out_green = out_green_r;
  assign out_blue  = out_blue_r;
  assign out_lit   = out_lit_r;

  // Ring pointer arithmetic
  assign wr_ptr      = (new_ptr_r == PTR_W'(HISTORY_DEPTH - 1)) ? '0 : new_ptr_r + 1'b1;
  assign rd_ptr_prev = (rd_ptr_r == '0) ? PTR_W'(HISTORY_DEPTH - 1) : rd_ptr_r - 1'b1;

  // History scan issues one read per cycle while entries remain
  assign rd_en = (state_r == ST_SCAN) && (iss_cnt_r < hist_cnt_r);

  slcm_ram #(
    .WIDTH (LEVEL_W),
    .DEPTH (HISTORY_DEPTH)
  ) u_hist (
    .clk     (clk),
    .wr_en   (fin_go),
    .wr_addr (wr_ptr),
    .wr_data (lv_r),
    .rd_en   (rd_en),
    .rd_addr (rd_ptr_r),
    .rd_data (rd_data)
  );

  // Channel served by the current operation
  always_comb begin
    case (op_r)
      OP_BLEND_R, OP_SCALE_R: ch_idx = CH_RED;
      OP_BLEND_G, OP_SCALE_G: ch_idx = CH_GREEN;
      default:                ch_idx = CH_BLUE;
    endcase
  end

  // Blend segment selection
  assign upper    = (fq_r >= cfg_mid_r);
  assign a_ch     = upper ? chan_of(cfg_mcol_r, ch_idx) : chan_of(cfg_low_r, ch_idx);
  assign b_ch     = upper ? chan_of(cfg_hcol_r, ch_idx) : chan_of(cfg_mcol_r, ch_idx);
  assign diff_neg = (b_ch < a_ch);
  assign dmag     = diff_neg ? a_ch - b_ch : b_ch - a_ch;
  assign seg_pos  = upper ? fq_r - cfg_mid_r : fq_r;
  assign seg_span = upper ? cfg_max_r - cfg_mid_r : cfg_mid_r - 1'b1;

  // Operand mux for the shared multiplier and divider
  always_comb begin
    case (op_r)
      OP_BRIGHT: begin
        mul_a = FREQ_W'(lv_r - lo_r);
        mul_b = CH_MAX;
        dvs   = FREQ_W'(hi_r - lo_r);
      end
      OP_BLEND_R, OP_BLEND_G, OP_BLEND_B: begin
        mul_a = seg_pos;
        mul_b = dmag;
        dvs   = seg_span;
      end
      OP_SCALE_R, OP_SCALE_G, OP_SCALE_B: begin
        mul_a = FREQ_W'(base_r[ch_idx]);
        mul_b = bright_r;
        dvs   = FREQ_W'(CH_MAX);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
        dvs   = '0;
      end
    endcase
  end

  assign mul_prod = PROD_W'(mul_a) * PROD_W'(mul_b);

  // One restoring division step; quotient always fits in 8 bits
  assign trial = {rem_r, quo_r[CH_W-1]};
  assign ge    = (trial >= {1'b0, dvs_r});

  assign lit_now = (lv_r > newest_r) && (fq_r >= cfg_min_r);

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_min_r   <= RST_MIN_FREQ;
      cfg_mid_r   <= RST_MID_FREQ;
      cfg_max_r   <= RST_MAX_FREQ;
      cfg_low_r   <= RST_LOW_COLOR;
      cfg_mcol_r  <= RST_MID_COLOR;
      cfg_hcol_r  <= RST_HI_COLOR;
      cfg_floor_r <= RST_LVL_FLOOR;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MIN_FREQ:  cfg_min_r   <= cfg_wdata[FREQ_W-1:0];
        REG_MID_FREQ:  cfg_mid_r   <= cfg_wdata[FREQ_W-1:0];
        REG_MAX_FREQ:  cfg_max_r   <= cfg_wdata[FREQ_W-1:0];
        REG_LOW_COLOR: cfg_low_r   <= cfg_wdata[COLOR_W-1:0];
        REG_MID_COLOR: cfg_mcol_r  <= cfg_wdata[COLOR_W-1:0];
        REG_HI_COLOR:  cfg_hcol_r  <= cfg_wdata[COLOR_W-1:0];
        REG_LVL_FLOOR: cfg_floor_r <= cfg_wdata[LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rd_pend_r   <= 1'b0;
      hist_cnt_r  <= '0;
      new_ptr_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // result valid: loaded on finish, dropped once taken
      if (fin_go) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          rd_pend_r <= 1'b0;
          if (in_acc) begin
            state_r <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          rd_pend_r <= rd_en;
          if (!rd_en && !rd_pend_r) begin
            state_r <= ST_GATE;
          end
        end
        ST_GATE: begin
          state_r <= lit_now ? ST_MUL : ST_FIN;
        end
        ST_MUL: begin
          state_r <= ST_DIV;
        end
        ST_DIV: begin
          if (it_r == DIV_LAST) begin
            state_r <= ST_POST;
          end
        end
        ST_POST: begin
          state_r <= (op_r == OP_SCALE_B) ? ST_FIN : ST_MUL;
        end
        ST_FIN: begin
          if (fin_go) begin
            new_ptr_r   <= wr_ptr;
            if (hist_cnt_r < CNT_W'(HISTORY_DEPTH)) begin
              hist_cnt_r <= hist_cnt_r + 1'b1;
            end
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          lv_r      <= in_rms_level;
          fq_r      <= (in_peak_frequency > cfg_max_r) ? cfg_max_r : in_peak_frequency;
          lo_r      <= in_rms_level;
          hi_r      <= in_rms_level;
          newest_r  <= '0;
          got_new_r <= 1'b0;
          iss_cnt_r <= '0;
          rd_ptr_r  <= new_ptr_r;
        end
      end
      ST_SCAN: begin
        if (rd_en) begin
          iss_cnt_r <= iss_cnt_r + 1'b1;
          rd_ptr_r  <= rd_ptr_prev;
        end
        // first entry returned is the newest one
        if (rd_pend_r) begin
          if (rd_data < lo_r) lo_r <= rd_data;
          if (rd_data > hi_r) hi_r <= rd_data;
          if (!got_new_r) begin
            newest_r  <= rd_data;
            got_new_r <= 1'b1;
          end
        end
      end
      ST_GATE: begin
        lit_r <= lit_now;
        op_r  <= OP_BRIGHT;
        if (hi_r < cfg_floor_r) hi_r <= cfg_floor_r;
        rgb_r[0] <= '0;
        rgb_r[1] <= '0;
        rgb_r[2] <= '0;
      end
      ST_MUL: begin
        rem_r <= mul_prod[PROD_W-1:CH_W];
        quo_r <= mul_prod[CH_W-1:0];
        dvs_r <= dvs;
        it_r  <= '0;
      end
      ST_DIV: begin
        rem_r <= ge ? 16'(trial - {1'b0, dvs_r}) : trial[15:0];
        quo_r <= {quo_r[CH_W-2:0], ge};
        it_r  <= it_r + 1'b1;
      end
      ST_POST: begin
        case (op_r)
          OP_BRIGHT: begin
            // zero span gives zero brightness
            bright_r <= (dvs_r == '0) ? '0 : quo_r;
          end
          OP_BLEND_R, OP_BLEND_G, OP_BLEND_B: begin
            // zero span keeps the segment's start colour
            if (dvs_r == '0) begin
              base_r[ch_idx] <= a_ch;
            end else begin
              base_r[ch_idx] <= diff_neg ? a_ch - quo_r : a_ch + quo_r;
            end
          end
          OP_SCALE_R, OP_SCALE_G, OP_SCALE_B: begin
            rgb_r[ch_idx] <= quo_r;
          end
          default: ;
        endcase
        op_r <= op_r + 1'b1;
      end
      ST_FIN: begin
        if (fin_go) begin
          out_red_r   <= rgb_r[0];
          out_green_r <= rgb_r[1];
          out_blue_r  <= rgb_r[2];
          out_lit_r   <= lit_r;
        end
      end
      default: ;
    endcase
  end

  // Checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    hist_cnt_r <= CNT_W'(HISTORY_DEPTH))
    else $error("history count above depth");

  a_dark_unlit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_lit |-> (out_red == '0 && out_green == '0 && out_blue == '0))
    else $error("unlit item carries a colour");

  a_busy_after_acc: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second item accepted while busy");

  a_range_order: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_GATE |-> (lo_r <= lv_r && lv_r <= hi_r))
    else $error("level outside scanned range");

endmodule

// File: verif/sound_level_color_mapper_top_tb.sv
`timescale 1ns / 1ps

module sound_level_color_mapper_top_tb;
  import slcm_pkg::*;

  localparam int HIST_DEPTH = HIST_DEPTH_DEF;
  localparam int IDLE_LIMIT = 4000;
  localparam int LONG_HOLD  = 300;
  localparam int SETTLE     = 100;

  typedef struct packed {
    level_t level;
    freq_t  freq;
  } window_t;

  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
    logic  lit;
  } color_result_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  level_t    in_rms_level = '0;
  freq_t     in_peak_frequency = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  chan_t     out_red;
  chan_t     out_green;
  chan_t     out_blue;
  logic      out_lit;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  cfg_idx_t  cfg_index = '0;
  cfg_data_t cfg_wdata = '0;

  // register copies for prediction
  freq_t  min_freq_r;
  freq_t  mid_freq_r;
  freq_t  max_freq_r;
  color_t low_color_r;
  color_t mid_color_r;
  color_t high_color_r;
  level_t floor_r;

  level_t        level_hist[$];    // newest last
  window_t       window_queue[$];
  color_result_t color_expect[$];
  window_t       cur_window;
  color_result_t want;

  int windows_queued = 0;
  int windows_taken = 0;
  int results_seen = 0;
  int mismatch_count = 0;
  int idle_cycles = 0;
  int tx_gap = 0;
  int rx_gap = 0;
  int rx_hold = 0;
  bit long_hold_done = 1'b0;
  bit tx_quiet = 1'b0;
  bit rx_quiet = 1'b0;

  sound_level_color_mapper_top #(
    .HISTORY_DEPTH(HIST_DEPTH)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_rms_level     (in_rms_level),
    .in_peak_frequency(in_peak_frequency),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_red          (out_red),
    .out_green        (out_green),
    .out_blue         (out_blue),
    .out_lit          (out_lit),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(input string what);
    $display("%0t ns mismatch: %s", $time, what);
    mismatch_count++;
  endtask

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic longint chan_at(color_t rgb, int sh);
    return longint'((rgb >> sh) & 24'hFF);
  endfunction

  // linear blend, quotient truncated toward zero
  function automatic longint blend_chan(longint x, longint x0, longint x1,
                                        longint a, longint b);
    longint span;
    span = x1 - x0;
    if (span == 0) return a;
    return a + ((x - x0) * (b - a)) / span;
  endfunction

  // expected color for one window; also adds the level to the history
  function automatic void map_window(level_t level, freq_t freq_raw);
    color_result_t res;
    int unsigned   freq;
    int unsigned   newest;
    int unsigned   lo;
    int unsigned   hi;
    int unsigned   bright;
    longint        base;
    longint        scaled[3];
    int            sh;
    res = '0;
    scaled = '{0, 0, 0};
    freq = freq_raw;
    newest = (level_hist.size() != 0) ? level_hist[level_hist.size() - 1] : 0;
    if (freq > max_freq_r) freq = max_freq_r;
    if (level > newest && freq >= min_freq_r) begin
      res.lit = 1'b1;
      lo = level;
      hi = level;
      bright = 0;
      foreach (level_hist[k]) begin
        if (level_hist[k] < lo) lo = level_hist[k];
        if (level_hist[k] > hi) hi = level_hist[k];
      end
      if (hi < floor_r) hi = floor_r;
      if (hi != lo) bright = ((level - lo) * 255) / (hi - lo);
      for (int c = 0; c < 3; c++) begin
        sh = 16 - 8 * c;
        if (freq < mid_freq_r)
          base = blend_chan(freq, 0, longint'(mid_freq_r) - 1,
                            chan_at(low_color_r, sh), chan_at(mid_color_r, sh));
        else
          base = blend_chan(freq, mid_freq_r, max_freq_r,
                            chan_at(mid_color_r, sh), chan_at(high_color_r, sh));
        if (base < 0) base = 0;
        if (base > 255) base = 255;
        scaled[c] = (base * longint'(bright)) / 255;
      end
    end
    res.red   = chan_t'(scaled[0]);
    res.green = chan_t'(scaled[1]);
    res.blue  = chan_t'(scaled[2]);
    color_expect.push_back(res);
    // oldest entry drops out once the history is full
    level_hist.push_back(level);
    if (level_hist.size() > HIST_DEPTH) level_hist.delete(0);
  endfunction

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      tx_gap = 0;
    end else begin
      if (in_valid && !in_stall) begin
        map_window(in_rms_level, in_peak_frequency);
        windows_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_valid <= 1'b0;
        end else if (window_queue.size() != 0) begin
          cur_window = window_queue.pop_front();
          in_valid <= 1'b1;
          in_rms_level <= cur_window.level;
          in_peak_frequency <= cur_window.freq;
          tx_gap = tx_quiet ? 0 : pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver stall
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (color_expect.size() == 0) begin
          report_mismatch("result item with nothing expected");
        end else begin
          want = color_expect.pop_front();
          if (out_red !== want.red)
            report_mismatch($sformatf("red got %0d want %0d", out_red, want.red));
          if (out_green !== want.green)
            report_mismatch($sformatf("green got %0d want %0d", out_green, want.green));
          if (out_blue !== want.blue)
            report_mismatch($sformatf("blue got %0d want %0d", out_blue, want.blue));
          if (out_lit !== want.lit)
            report_mismatch($sformatf("lit got %0b want %0b", out_lit, want.lit));
        end
      end
      // one long hold-off so the block backs up into its input
      if (rx_hold > 0) begin
        rx_hold--;
        out_stall <= 1'b1;
      end else if (!long_hold_done && results_seen >= 40) begin
        long_hold_done = 1'b1;
        rx_hold = LONG_HOLD - 1;
        out_stall <= 1'b1;
      end else if (rx_gap > 0) begin
        rx_gap--;
        out_stall <= 1'b1;
      end else begin
        rx_gap = rx_quiet ? 0 : pick_gap();
        if (rx_gap > 0) begin
          rx_gap--;
          out_stall <= 1'b1;
        end else begin
          out_stall <= 1'b0;
        end
      end
    end
  end

  // watchdog: cycles with no handshake on any channel
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout after %0d idle cycles", idle_cycles);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  task automatic write_reg(input cfg_idx_t idx, input cfg_data_t data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_MIN_FREQ:  min_freq_r = data[FREQ_W-1:0];
      REG_MID_FREQ:  mid_freq_r = data[FREQ_W-1:0];
      REG_MAX_FREQ:  max_freq_r = data[FREQ_W-1:0];
      REG_LOW_COLOR: low_color_r = data[COLOR_W-1:0];
      REG_MID_COLOR: mid_color_r = data[COLOR_W-1:0];
      REG_HI_COLOR:  high_color_r = data[COLOR_W-1:0];
      REG_LVL_FLOOR: floor_r = data[LEVEL_W-1:0];
      default: ;
    endcase
  endtask

  task automatic write_all(input freq_t min_f, input freq_t mid_f, input freq_t max_f,
                           input color_t low_c, input color_t mid_c, input color_t high_c,
                           input level_t lvl_floor);
    write_reg(REG_MIN_FREQ, cfg_data_t'(min_f));
    write_reg(REG_MID_FREQ, cfg_data_t'(mid_f));
    write_reg(REG_MAX_FREQ, cfg_data_t'(max_f));
    write_reg(REG_LOW_COLOR, cfg_data_t'(low_c));
    write_reg(REG_MID_COLOR, cfg_data_t'(mid_c));
    write_reg(REG_HI_COLOR, cfg_data_t'(high_c));
    write_reg(REG_LVL_FLOOR, cfg_data_t'(lvl_floor));
  endtask

  task automatic queue_window(input level_t level, input freq_t freq);
    window_t w;
    w.level = level;
    w.freq = freq;
    window_queue.push_back(w);
    windows_queued++;
  endtask

  // mostly inside the lit band, sometimes on a boundary or anywhere
  function automatic freq_t pick_freq();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return freq_t'($urandom_range(0, 65535));
    if (r == 1) begin
      case ($urandom_range(0, 7))
        0: return '0;
        1: return min_freq_r;
        2: return min_freq_r - 1'b1;
        3: return mid_freq_r;
        4: return mid_freq_r - 1'b1;
        5: return max_freq_r;
        6: return max_freq_r + 1'b1;
        default: return '1;
      endcase
    end
    if (min_freq_r <= max_freq_r) return freq_t'($urandom_range(min_freq_r, max_freq_r));
    return freq_t'($urandom_range(0, 65535));
  endfunction

  // rising runs light the output; the rest is noise
  task automatic run_random(input int count);
    int left;
    int run_len;
    int lvl;
    left = count;
    while (left > 0) begin
      if ($urandom_range(0, 9) < 7) begin
        run_len = $urandom_range(3, 10);
        lvl = $urandom_range(0, 300);
        repeat (run_len) begin
          queue_window(level_t'(lvl), pick_freq());
          lvl = lvl + $urandom_range(1, 90);
          if (lvl > 1023) lvl = 1023;
        end
        left -= run_len;
      end else begin
        queue_window(level_t'($urandom_range(0, 1023)), freq_t'($urandom_range(0, 65535)));
        left--;
      end
    end
  endtask

  // sender holds until every item is taken and every result is back
  task automatic settle();
    while (windows_taken != windows_queued || color_expect.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic pick_idling();
    tx_quiet = ($urandom_range(0, 3) == 0);
    rx_quiet = ($urandom_range(0, 3) == 0);
  endtask

  freq_t max_pick;

  initial begin
    min_freq_r   = RST_MIN_FREQ;
    mid_freq_r   = RST_MID_FREQ;
    max_freq_r   = RST_MAX_FREQ;
    low_color_r  = RST_LOW_COLOR;
    mid_color_r  = RST_MID_COLOR;
    high_color_r = RST_HI_COLOR;
    floor_r      = RST_LVL_FLOOR;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed: defaults, empty history first (zero brightness span)
    tx_quiet = 1'b1;
    rx_quiet = 1'b1;
    queue_window(10'd100, 16'd300);
    queue_window(10'd0, 16'd0);
    queue_window(10'd1023, 16'hFFFF);
    queue_window(10'd1023, 16'd1000);
    queue_window(10'd5, 16'd59);
    queue_window(10'd6, 16'd60);
    queue_window(10'd7, 16'd499);
    queue_window(10'd8, 16'd500);
    queue_window(10'd9, 16'd2000);
    queue_window(10'd10, 16'd2001);
    queue_window(10'd0, 16'd1000);
    queue_window(10'd512, 16'd0);
    queue_window(10'd513, 16'd250);
    queue_window(10'd700, 16'd1250);
    queue_window(10'd341, 16'h5555);
    queue_window(10'd682, 16'hAAAA);
    queue_window(10'd683, 16'd1999);
    settle();

    // low extremes: both blend segments have zero span
    pick_idling();
    write_all(16'd0, 16'd1, 16'd1, 24'h000000, 24'hFFFFFF, color_t'($urandom), 10'd0);
    queue_window(10'd1, 16'd0);
    queue_window(10'd2, 16'd1);
    queue_window(10'd3, 16'hFFFF);
    run_random(40);
    settle();

    // high extremes
    pick_idling();
    write_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 24'hFFFFFF, 24'h000000, 24'hFFFFFF, 10'd1023);
    run_random(40);
    settle();

    // mid frequency of zero: always the upper segment
    pick_idling();
    write_all(16'd0, 16'd0, 16'd3000, color_t'($urandom), color_t'($urandom),
              color_t'($urandom), 10'd200);
    run_random(50);
    settle();

    // random settings
    repeat (5) begin
      pick_idling();
      max_pick = ($urandom_range(0, 1) == 0) ? freq_t'($urandom_range(1, 65535))
                                             : freq_t'($urandom_range(100, 5000));
      write_all(freq_t'($urandom_range(0, max_pick)), freq_t'($urandom_range(1, 65535)),
                max_pick, color_t'($urandom), color_t'($urandom), color_t'($urandom),
                level_t'($urandom_range(0, 1023)));
      if ($urandom_range(0, 1) == 0)
        write_reg(REG_MID_FREQ, cfg_data_t'($urandom_range(1, max_pick)));
      run_random(50);
      settle();
    end

    // back to the reset settings
    pick_idling();
    write_all(RST_MIN_FREQ, RST_MID_FREQ, RST_MAX_FREQ, RST_LOW_COLOR, RST_MID_COLOR,
              RST_HI_COLOR, RST_LVL_FLOOR);
    run_random(40);
    settle();

    if (mismatch_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
